>>> hw/rtl/tpc_pkg.sv
// shared types and constants of the trackball pointer and cursor step block
// no dependencies

package tpc_pkg;

   localparam int THR_W = 8;
   localparam logic [THR_W-1:0] THR_RESET = 8'd25;
   localparam logic [3:0] DIV_TEN = 4'd10;
   localparam logic [6:0] CLIP_MAX = 7'd127;

   localparam logic [1:0] KEY_UP = 2'd0;
   localparam logic [1:0] KEY_DOWN = 2'd1;
   localparam logic [1:0] KEY_LEFT = 2'd2;
   localparam logic [1:0] KEY_RIGHT = 2'd3;

   typedef struct packed {
      logic load;
      logic step;
   } div_ctl_type;

   // gain in tenths, size already clamped to 127
   function automatic logic [4:0] gain_tenths(input logic [6:0] size);
      logic [4:0] g;
      if (size > 7'd60) begin
         g = 5'd30;
      end else if (size > 7'd30) begin
         g = 5'd15;
      end else if (size > 7'd5) begin
         g = 5'd10;
      end else begin
         case (size)
            7'd5: g = 5'd9;
            7'd4: g = 5'd7;
            7'd3: g = 5'd5;
            7'd2: g = 5'd2;
            default: g = 5'd10;
         endcase
      end
      return g;
   endfunction

endpackage

>>> hw/rtl/tpc_div_lane.sv
// one lane of the bit-serial restoring divider, one quotient bit per cycle while step is set
// depends on tpc_pkg

module tpc_div_lane #(
   parameter int DW = 21
) (
   input  logic                     clock,
   input  tpc_pkg::div_ctl_type     ctl,
   input  logic [DW-1:0]            dividend,
   input  logic [tpc_pkg::THR_W-1:0] divisor,
   output logic [DW-1:0]            quotient,
   output logic [tpc_pkg::THR_W-1:0] remainder
);
   import tpc_pkg::*;

   logic [DW-1:0]    shr_ff, shr_in;
   logic [THR_W-1:0] rem_ff, rem_in;
   logic [THR_W:0]   trial;
   logic [THR_W+1:0] diff;
   logic             ge;

   always_comb begin
      trial = {rem_ff, shr_ff[DW-1]};
      diff = {1'b0, trial} - {2'b00, divisor};
      ge = !diff[THR_W+1];
      shr_in = shr_ff;
      rem_in = rem_ff;
      if (ctl.load) begin
         shr_in = dividend;
         rem_in = '0;
      end else if (ctl.step) begin
         shr_in = {shr_ff[DW-2:0], ge};
         rem_in = ge ? diff[THR_W-1:0] : trial[THR_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      shr_ff <= shr_in;
      rem_ff <= rem_in;
   end

   assign quotient = shr_ff;
   assign remainder = rem_ff;

endmodule

>>> hw/rtl/trackball_pointer_and_cursor_step.sv
// top level of the trackball pointer and cursor step block
// depends on tpc_pkg and tpc_div_lane

// usage:
//   req channel: one trackball sample per transfer, deltas in tdata,
//   mode and hand flags in tuser. rsp channel: one result per sample.
//   csr channel: writes step_threshold, always ready; write only when idle.
// timing:
//   the bit-serial dividers produce one quotient bit per cycle over
//   ACCUM_WIDTH + 5 bits; both axes divide in parallel lanes. one
//   sample is in work at a time.
// reset:
//   accumulators clear, threshold returns to 25, no result pending.
// stall:
//   the result sits in an output register; the next sample is taken and
//   worked on while it waits, and its own result holds until the
//   register is free.
module trackball_pointer_and_cursor_step #(
   parameter int ACCUM_WIDTH = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,  // delta_x, delta_y
   input  logic [1:0]  req_tuser,  // action, left_hand
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,  // pointer_x, pointer_y, key_code, zero fill
   output logic [0:0]  rsp_tuser,  // key_valid
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [7:0]  csr_data    // step_threshold
);
   import tpc_pkg::*;

   localparam int W = ACCUM_WIDTH;
   localparam int DW = W + 5;
   localparam int CNT_W = $clog2(DW);

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_PREP = 2'd1;
   localparam logic [1:0] S_DIV  = 2'd2;
   localparam logic [1:0] S_DONE = 2'd3;

   logic [1:0]       state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [W-1:0]     ax_ff, ax_in, ay_ff, ay_in;
   logic             mode_ff, mode_in, left_ff, left_in;
   logic [THR_W-1:0] thr_ff, thr_in;
   logic             rv_ff, rv_in;
   logic [23:0]      rd_ff, rd_in;
   logic             ru_ff, ru_in;

   div_ctl_type      ctl;
   logic [DW-1:0]    dvd_x, dvd_y, qx, qy;
   logic [THR_W-1:0] divisor, rx, ry;

   logic [W:0]       size;
   logic [W-1:0]     sat_x, sat_y, mag_x, mag_y;
   logic [6:0]       size_c;
   logic [4:0]       gain;
   logic [6:0]       clip_x, clip_y;
   logic [7:0]       out_px, out_py;
   logic             kv;
   logic [1:0]       kc;
   logic             nx, ny, accept, out_free;

   function automatic logic [W-1:0] sat_add(input logic [W-1:0] a, input logic [7:0] d);
      logic [W:0] s;
      logic [W-1:0] r;
      s = {a[W-1], a} + {{(W-7){d[7]}}, d};
      if (s[W] != s[W-1]) begin
         r = s[W] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
      end else begin
         r = s[W-1:0];
      end
      return r;
   endfunction

   assign req_tready = (state_ff == S_IDLE);
   assign accept = req_tvalid && req_tready;
   assign csr_ready = 1'b1;
   assign out_free = !rv_ff || rsp_tready;

   always_comb begin
      sat_x = sat_add(ax_ff, req_tdata[7:0]);
      sat_y = sat_add(ay_ff, req_tdata[15:8]);
      nx = ax_ff[W-1];
      ny = ay_ff[W-1];
      mag_x = nx ? (~ax_ff + 1'b1) : ax_ff;
      mag_y = ny ? (~ay_ff + 1'b1) : ay_ff;
      size = {1'b0, mag_x} + {1'b0, mag_y};
      size_c = (size[W:7] != '0) ? CLIP_MAX : size[6:0];
      gain = gain_tenths(size_c);
      if (mode_ff) begin
         dvd_x = {5'd0, mag_x};
         dvd_y = {5'd0, mag_y};
         divisor = thr_ff;
      end else begin
         dvd_x = DW'(mag_x * gain);
         dvd_y = DW'(mag_y * gain);
         divisor = {{(THR_W-4){1'b0}}, DIV_TEN};
      end
      clip_x = (qx > DW'(CLIP_MAX)) ? CLIP_MAX : qx[6:0];
      clip_y = (qy > DW'(CLIP_MAX)) ? CLIP_MAX : qy[6:0];
      // axes swap: pointer_x from y, pointer_y from x
      out_px = (ny ^ left_ff) ? (8'd0 - {1'b0, clip_y}) : {1'b0, clip_y};
      out_py = (nx ^ left_ff) ? (8'd0 - {1'b0, clip_x}) : {1'b0, clip_x};
      kv = 1'b0;
      kc = KEY_UP;
      if (qx != '0 && qx >= qy) begin
         kv = 1'b1;
         kc = (nx != left_ff) ? KEY_UP : KEY_DOWN;
      end else if (qy != '0) begin
         kv = 1'b1;
         kc = (ny != left_ff) ? KEY_LEFT : KEY_RIGHT;
      end
   end

   always_comb begin
      state_in = state_ff;
      cnt_in = cnt_ff;
      ax_in = ax_ff;
      ay_in = ay_ff;
      mode_in = mode_ff;
      left_in = left_ff;
      thr_in = csr_valid ? csr_data : thr_ff;
      rv_in = rv_ff && !rsp_tready;
      rd_in = rd_ff;
      ru_in = ru_ff;
      ctl.load = 1'b0;
      ctl.step = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               ax_in = sat_x;
               ay_in = sat_y;
               mode_in = req_tuser[0];
               left_in = req_tuser[1];
               state_in = S_PREP;
            end
         end
         S_PREP: begin
            ctl.load = 1'b1;
            cnt_in = CNT_W'(DW - 1);
            state_in = S_DIV;
         end
         S_DIV: begin
            ctl.step = 1'b1;
            cnt_in = cnt_ff - 1'b1;
            if (cnt_ff == '0) begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (out_free) begin
               rv_in = 1'b1;
               state_in = S_IDLE;
               if (!mode_ff) begin
                  rd_in = {8'd0, out_py, out_px};
                  ru_in = 1'b0;
                  ax_in = '0;
                  ay_in = '0;
               end else if (thr_ff == '0) begin
                  rd_in = '0;
                  ru_in = 1'b0;
               end else begin
                  rd_in = {6'd0, kc, 16'd0};
                  ru_in = kv;
                  ax_in = nx ? (W'(0) - W'(rx)) : W'(rx);
                  ay_in = ny ? (W'(0) - W'(ry)) : W'(ry);
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         ax_ff <= '0;
         ay_ff <= '0;
         thr_ff <= THR_RESET;
         rv_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         ax_ff <= ax_in;
         ay_ff <= ay_in;
         thr_ff <= thr_in;
         rv_ff <= rv_in;
      end
      cnt_ff <= cnt_in;
      mode_ff <= mode_in;
      left_ff <= left_in;
      rd_ff <= rd_in;
      ru_ff <= ru_in;
   end

   tpc_div_lane #(.DW(DW)) u_lane_x (
      .clock     (clock),
      .ctl       (ctl),
      .dividend  (dvd_x),
      .divisor   (divisor),
      .quotient  (qx),
      .remainder (rx)
   );

   tpc_div_lane #(.DW(DW)) u_lane_y (
      .clock     (clock),
      .ctl       (ctl),
      .dividend  (dvd_y),
      .divisor   (divisor),
      .quotient  (qy),
      .remainder (ry)
   );

   assign rsp_tvalid = rv_ff;
   assign rsp_tdata = rd_ff;
   assign rsp_tuser = ru_ff;

endmodule
